// File: src/ambisonic_gain_encoder_zc_swap_defines.svh
// Assertion macros for the checker file of the encoder.
`ifndef AMBISONIC_GAIN_ENCODER_ZC_SWAP_DEFINES_SVH
`define AMBISONIC_GAIN_ENCODER_ZC_SWAP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define AGZ_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define AGZ_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: src/agz_pkg.sv
package agz_pkg;

    // Fixed field widths.
    localparam int CMD_BITS   = 2;
    localparam int IDX_BITS   = 6;
    localparam int COEF_BITS  = 20;
    localparam int ORDER_BITS = 3;
    localparam int FRAC_SHIFT = 16;
    // Holds a channel count up to 64.
    localparam int CNT_BITS   = 7;

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_ENCODE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;

    // Configuration register indexes (register address bit 2).
    localparam logic REG_ORDER  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // Control from the sequencer to the coefficient banks.
    typedef struct packed {
        logic                        sh_we;
        logic [IDX_BITS-1:0]         sh_waddr;
        logic signed [COEF_BITS-1:0] sh_wdata;
        logic [IDX_BITS-1:0]         sh_raddr;
        logic                        act_we;
        logic [IDX_BITS-1:0]         act_waddr;
        logic [IDX_BITS-1:0]         act_raddr;
    } t_bank_ctl;

endpackage

// File: src/agz_if.sv
// Command channel into the encoder.
interface agz_in_if import agz_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic [CMD_BITS-1:0]           cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_BITS-1:0]           coeff_index;
    logic signed [COEF_BITS-1:0]   coeff_value;

    modport source (output valid, cmd, sample, coeff_index, coeff_value, input ready);
    modport sink (input valid, cmd, sample, coeff_index, coeff_value, output ready);
endinterface

// Result channel out of the encoder.
interface agz_out_if import agz_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic [IDX_BITS-1:0]           channel;
    logic signed [SAMPLE_BITS-1:0] result_value;
    logic                          last;

    modport source (output valid, channel, result_value, last, input ready);
    modport sink (input valid, channel, result_value, last, output ready);
endinterface

// File: src/agz_bank.sv
// Shadow and active coefficient memories. Each has one write and one
// registered read port; per-entry valid bits make unwritten entries read zero.
module agz_bank import agz_pkg::*; #(
    parameter int MAX_CHANNELS = 36
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_bank_ctl                   i_ctl,
    output logic signed [COEF_BITS-1:0] o_act_rdata
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [COEF_BITS-1:0]    r_shadow [MAX_CHANNELS];
    logic [COEF_BITS-1:0]    r_active [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_sh_valid;
    logic [MAX_CHANNELS-1:0] r_act_valid;
    logic [COEF_BITS-1:0]    r_sh_rdata;
    logic                    r_sh_rvalid;
    logic [COEF_BITS-1:0]    r_act_rdata;
    logic                    r_act_rvalid;
    logic [COEF_BITS-1:0]    w_copy_data;

    // A copy moves the shadow entry read in the previous cycle.
    assign w_copy_data = r_sh_rvalid ? r_sh_rdata : '0;
    assign o_act_rdata = r_act_rvalid ? $signed(r_act_rdata) : '0;

    // Shadow memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sh_we) begin
            r_shadow[i_ctl.sh_waddr[AW-1:0]] <= i_ctl.sh_wdata;
        end
        r_sh_rdata  <= r_shadow[i_ctl.sh_raddr[AW-1:0]];
        r_sh_rvalid <= r_sh_valid[i_ctl.sh_raddr[AW-1:0]];
    end

    // Active memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.act_we) begin
            r_active[i_ctl.act_waddr[AW-1:0]] <= w_copy_data;
        end
        r_act_rdata  <= r_active[i_ctl.act_raddr[AW-1:0]];
        r_act_rvalid <= r_act_valid[i_ctl.act_raddr[AW-1:0]];
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_valid  <= '0;
            r_act_valid <= '0;
        end else begin
            if (i_ctl.sh_we) begin
                r_sh_valid[i_ctl.sh_waddr[AW-1:0]] <= 1'b1;
            end
            if (i_ctl.act_we) begin
                r_act_valid[i_ctl.act_waddr[AW-1:0]] <= 1'b1;
            end
        end
    end

endmodule

// File: src/agz_scale.sv
// Shared multiplier: registers sample times coefficient, then rounds half up
// and saturates the registered product to the sample width.
module agz_scale import agz_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [COEF_BITS-1:0]   i_coeff,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam logic [PW:0] ROUND = (PW + 1)'(64'd1 << (FRAC_SHIFT - 1));

    logic signed [PW-1:0] r_prod;
    logic [PW:0]          w_sum;
    logic [PW-FRAC_SHIFT-SAMPLE_BITS+1:0] w_top;

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_sample) * PW'(i_coeff);
        end
    end

    // Round half up, then clamp when the kept bits do not fit.
    assign w_sum = {r_prod[PW-1], r_prod} + ROUND;
    assign w_top = w_sum[PW:FRAC_SHIFT+SAMPLE_BITS-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_result = $signed(w_sum[FRAC_SHIFT+SAMPLE_BITS-1:FRAC_SHIFT]);
        end else if (w_sum[PW]) begin
            o_result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

// File: src/ambisonic_gain_encoder_zc_swap.sv
// Ambisonic gain encoder with a zero-crossing coefficient swap.
// i_in carries commands: encode a sample, write a shadow coefficient, or read
// an active coefficient. o_out carries results (channel, value, last).
// Registers sit on the APB port: ambisonic order at 0x0, swap threshold at 0x4.
// An encode gives N = (order+1)^2 results (capped at MAX_CHANNELS) from one
// shared multiplier: S_RD reads the first coefficient, then S_MUL registers
// the product and S_OUT loads the rounded result, once per channel.
// When a swap is pending and the sample magnitude is below the threshold, the
// whole shadow bank is first copied into the active bank, one entry per pass
// through S_COPY_RD and S_COPY_WR. A coefficient write gives no result; a read
// gives one result, loaded into the output register from S_RDCMD.
// i_in.ready is high only while the sequencer is idle. Results go through an
// output register, so a new item may be taken while the last result of the
// previous one waits; a stalled receiver holds the sequencer at its next result.
// Synchronous reset clears both coefficient banks to zero, the swap flag, and
// restores order 1 and a threshold of about 1e-3 of full scale.
module ambisonic_gain_encoder_zc_swap import agz_pkg::*; #(
    parameter int MAX_CHANNELS = 36,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    agz_in_if.sink        i_in,
    agz_out_if.source     o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [SAMPLE_BITS-2:0] THRESH_RESET =
        (SAMPLE_BITS - 1)'(((64'd1 << (SAMPLE_BITS - 1)) + 64'd500) / 64'd1000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_RD,
        S_MUL,
        S_OUT,
        S_RDCMD
    } t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [IDX_BITS-1:0]           r_idx;
    logic                          r_inrange;
    logic                          r_pending;
    logic [ORDER_BITS-1:0]         r_order;
    logic [SAMPLE_BITS-2:0]        r_thresh;
    logic                          r_out_valid;
    logic [IDX_BITS-1:0]           r_out_channel;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_last;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [3:0]                    w_ord_p1;
    logic [7:0]                    w_sq;
    logic [CNT_BITS-1:0]           w_nchan;
    logic                          w_idx_ok;
    logic [SAMPLE_BITS-1:0]        w_mag;
    logic                          w_swap;
    logic                          w_last_ch;
    logic                          w_copy_end;
    logic [AW-1:0]                 w_cnt_inc;
    logic                          w_cfg_we;
    t_bank_ctl                     w_bank_ctl;
    logic signed [COEF_BITS-1:0]   w_act_rdata;
    logic signed [SAMPLE_BITS-1:0] w_scaled;
    logic signed [SAMPLE_BITS-1:0] w_rd_value;

    // Handshakes.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = ((r_state == S_OUT) || (r_state == S_RDCMD)) && w_out_free;

    assign o_out.valid        = r_out_valid;
    assign o_out.channel      = r_out_channel;
    assign o_out.result_value = r_out_value;
    assign o_out.last         = r_out_last;

    // Channel count: (order+1)^2 capped at the bank depth.
    assign w_ord_p1 = {1'b0, r_order} + 4'd1;
    assign w_sq     = w_ord_p1 * w_ord_p1;
    assign w_nchan  = (w_sq > 8'(MAX_CHANNELS)) ? CNT_BITS'(MAX_CHANNELS)
                                                : w_sq[CNT_BITS-1:0];
    assign w_idx_ok = ({1'b0, i_in.coeff_index} < w_nchan);

    // Swap test on the incoming sample magnitude.
    assign w_mag  = i_in.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.sample)
                                               : SAMPLE_BITS'(i_in.sample);
    assign w_swap = r_pending && (w_mag < {1'b0, r_thresh});

    assign w_last_ch  = (CNT_BITS'(r_cnt) == (w_nchan - CNT_BITS'(1)));
    assign w_copy_end = (r_cnt == AW'(MAX_CHANNELS - 1));
    assign w_cnt_inc  = r_cnt + AW'(1);

    // Bank control.
    always_comb begin
        w_bank_ctl          = '0;
        w_bank_ctl.sh_we    = w_in_acc && (i_in.cmd == CMD_WRITE) && w_idx_ok;
        w_bank_ctl.sh_waddr = i_in.coeff_index;
        w_bank_ctl.sh_wdata = i_in.coeff_value;
        w_bank_ctl.sh_raddr = IDX_BITS'(r_cnt);
        w_bank_ctl.act_we   = (r_state == S_COPY_WR);
        w_bank_ctl.act_waddr = IDX_BITS'(r_cnt);
        case (r_state)
            S_IDLE:  w_bank_ctl.act_raddr = w_idx_ok ? i_in.coeff_index : '0;
            S_RDCMD: w_bank_ctl.act_raddr = r_inrange ? r_idx : '0;
            S_OUT:   w_bank_ctl.act_raddr = w_last_ch ? '0 : IDX_BITS'(w_cnt_inc);
            default: w_bank_ctl.act_raddr = IDX_BITS'(r_cnt);
        endcase
    end

    agz_bank #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_bank_ctl),
        .o_act_rdata (w_act_rdata)
    );

    agz_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_en     (r_state == S_MUL),
        .i_sample (r_sample),
        .i_coeff  (w_act_rdata),
        .o_result (w_scaled)
    );

    // Read result: coefficient sign-extended, zero when out of range.
    assign w_rd_value = r_inrange ? SAMPLE_BITS'(w_act_rdata) : '0;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    always_comb begin
        case (paddr[2])
            REG_ORDER:  prdata = 32'(r_order);
            REG_THRESH: prdata = 32'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    // Sequencer, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pending   <= 1'b0;
            r_order     <= ORDER_BITS'(1);
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
            r_inrange   <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                case (paddr[2])
                    REG_ORDER:  r_order  <= pwdata[ORDER_BITS-1:0];
                    REG_THRESH: r_thresh <= pwdata[SAMPLE_BITS-2:0];
                    default:    ;
                endcase
            end

            // A new result fills the output register; a taken one empties it.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sample  <= i_in.sample;
                        r_idx     <= i_in.coeff_index;
                        r_inrange <= w_idx_ok;
                        r_cnt     <= '0;
                        case (i_in.cmd)
                            CMD_ENCODE: r_state <= w_swap ? S_COPY_RD : S_RD;
                            CMD_WRITE: begin
                                if (w_idx_ok) begin
                                    r_pending <= 1'b1;
                                end
                            end
                            CMD_READ:   r_state <= S_RDCMD;
                            default:    ;
                        endcase
                    end
                end
                S_COPY_RD: r_state <= S_COPY_WR;
                S_COPY_WR: begin
                    if (w_copy_end) begin
                        r_cnt     <= '0;
                        r_pending <= 1'b0;
                        r_state   <= S_RD;
                    end else begin
                        r_cnt   <= w_cnt_inc;
                        r_state <= S_COPY_RD;
                    end
                end
                S_RD:  r_state <= S_MUL;
                S_MUL: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_channel <= IDX_BITS'(r_cnt);
                        r_out_value   <= w_scaled;
                        r_out_last    <= w_last_ch;
                        if (w_last_ch) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= w_cnt_inc;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_RDCMD: begin
                    if (w_out_free) begin
                        r_out_channel <= r_idx;
                        r_out_value   <= w_rd_value;
                        r_out_last    <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/agz_chk.sv
`include "ambisonic_gain_encoder_zc_swap_defines.svh"

// Port-level checks of the encoder.
module agz_chk import agz_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [CMD_BITS-1:0] i_in_cmd,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_last
);

    logic w_in_acc;
    logic w_no_result;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_no_result = (i_in_cmd != CMD_ENCODE) && (i_in_cmd != CMD_READ);

    // A stalled result stays offered.
    `AGZ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid,
        "result dropped while stalled")

    // An item that produces results keeps the block busy in the next cycle.
    `AGZ_ASSERT_NEXT(a_busy_after_work, i_clk, i_rst_n, w_in_acc && !w_no_result, !i_in_ready,
        "ready after an item that produces results")

    // A write or an unused command leaves the block ready and adds no result.
    `AGZ_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, w_in_acc && w_no_result && !i_out_valid,
        i_in_ready && !i_out_valid, "item without results changed the outputs")

    // While an encode is part way through, no new item is taken.
    `AGZ_ASSERT_NOW(a_mid_encode_busy, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready,
        "ready in the middle of an encode")

endmodule

bind ambisonic_gain_encoder_zc_swap agz_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last)
);

// File: sim/ambisonic_gain_encoder_zc_swap_test.sv
module ambisonic_gain_encoder_zc_swap_test;
    import agz_pkg::*;

    localparam int MAX_CH   = 36;
    localparam int SAMPLE_W = 24;
    localparam int THRESH_W = SAMPLE_W - 1;

    // Command code three has no meaning and must be dropped by the block.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    // Longest receiver hold-off, the quiet time before a register write and
    // the number of quiet cycles after which the run is declared hung.
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 56;

    typedef struct packed {
        logic [CMD_BITS-1:0]        cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_BITS-1:0]        index;
        logic signed [COEF_BITS-1:0] coeff;
    } encoder_cmd_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]        channel;
        logic signed [SAMPLE_W-1:0] value;
        logic                       is_last;
    } encoder_result_t;

    // Tracks both coefficient banks and the registers, and holds the results
    // that each accepted command is expected to produce.
    class gain_matrix_scoreboard;
        logic [ORDER_BITS-1:0]       order;
        logic [THRESH_W-1:0]         threshold;
        logic signed [COEF_BITS-1:0] active_coeffs [MAX_CH];
        logic signed [COEF_BITS-1:0] shadow_coeffs [MAX_CH];
        bit                          swap_pending;
        encoder_result_t             expected_results [$];
        int unsigned                 mismatches;

        function new();
            order        = 3'd1;
            threshold    = 23'd8389;
            swap_pending = 1'b0;
            mismatches   = 0;
            for (int i = 0; i < MAX_CH; i++) begin
                active_coeffs[i] = '0;
                shadow_coeffs[i] = '0;
            end
        endfunction

        function int unsigned num_channels();
            int unsigned n;
            n = (int'(order) + 1) * (int'(order) + 1);
            return (n > MAX_CH) ? MAX_CH : n;
        endfunction

        function void write_register(logic reg_sel, logic [31:0] data);
            if (reg_sel == REG_ORDER) begin
                order = data[ORDER_BITS-1:0];
            end else begin
                threshold = data[THRESH_W-1:0];
            end
        endfunction

        // Q1.23 times Q4.16, rounded half up at bit 16, then saturated.
        function logic signed [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] s,
                                                          logic signed [COEF_BITS-1:0] c);
            longint prod;
            prod = (longint'(s) * longint'(c) + 64'sd32768) >>> FRAC_SHIFT;
            if (prod > 64'sd8388607) begin
                prod = 64'sd8388607;
            end else if (prod < -64'sd8388608) begin
                prod = -64'sd8388608;
            end
            return prod[SAMPLE_W-1:0];
        endfunction

        function void note_command(encoder_cmd_t c);
            int unsigned     n;
            int unsigned     k;
            longint          mag;
            encoder_result_t r;
            n = num_channels();
            case (c.cmd)
                CMD_ENCODE: begin
                    // A quiet sample takes over the pending bank before scaling.
                    mag = (c.sample < 0) ? -longint'(c.sample) : longint'(c.sample);
                    if (swap_pending && mag < longint'(threshold)) begin
                        active_coeffs = shadow_coeffs;
                        swap_pending  = 1'b0;
                    end
                    for (k = 0; k < n; k++) begin
                        r.channel = IDX_BITS'(k);
                        r.value   = scale_sample(c.sample, active_coeffs[k]);
                        r.is_last = (k + 1 == n);
                        expected_results.push_back(r);
                    end
                end
                CMD_WRITE: begin
                    if (c.index < n) begin
                        shadow_coeffs[c.index] = c.coeff;
                        swap_pending = 1'b1;
                    end
                end
                CMD_READ: begin
                    r.channel = c.index;
                    if (c.index < n) begin
                        r.value = active_coeffs[c.index];
                    end else begin
                        r.value = '0;
                    end
                    r.is_last = 1'b1;
                    expected_results.push_back(r);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(encoder_result_t got);
            encoder_result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: channel %0d result_value %0d last %0b",
                       got.channel, got.value, got.is_last);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.channel !== want.channel) begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                mismatches++;
            end
            if (got.value !== want.value) begin
                $error("result_value: expected %0d, got %0d", want.value, got.value);
                mismatches++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last: expected %0b, got %0b", want.is_last, got.is_last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    agz_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    agz_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

    gain_matrix_scoreboard sb;

    bit          traffic_steady  = 1'b0;
    bit          rx_hold_request = 1'b0;
    int unsigned idle_cycles     = 0;

    ambisonic_gain_encoder_zc_swap #(
        .MAX_CHANNELS(MAX_CH),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned sender_gap();
        if (traffic_steady || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_gap();
    endfunction

    function automatic encoder_cmd_t make_command(logic [CMD_BITS-1:0] cmd,
                                                  int sample, int index, int coeff);
        encoder_cmd_t c;
        c.cmd    = cmd;
        c.sample = sample[SAMPLE_W-1:0];
        c.index  = index[IDX_BITS-1:0];
        c.coeff  = coeff[COEF_BITS-1:0];
        return c;
    endfunction

    // Mostly encodes, half of them with samples near the threshold that can trigger
    // the swap, mixed with coefficient updates, reads and some noise.
    function automatic encoder_cmd_t random_command();
        encoder_cmd_t c;
        int unsigned  pick;
        int unsigned  n;
        int unsigned  span;
        int unsigned  mag;
        n        = sb.num_channels();
        pick     = $urandom_range(0, 99);
        c.sample = SAMPLE_W'($urandom);
        c.index  = IDX_BITS'($urandom);
        c.coeff  = COEF_BITS'($urandom);
        if (pick < 40) begin
            c.cmd = CMD_ENCODE;
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    span = (sb.threshold > 23'd4194303) ? 8388607 : 2 * sb.threshold;
                    mag  = $urandom_range(0, span);
                    c.sample = mag[SAMPLE_W-1:0];
                    if ($urandom_range(0, 1) == 1) begin
                        c.sample = -c.sample;
                    end
                end
                3: begin
                    c.sample = ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
                end
                default: begin
                end
            endcase
        end else if (pick < 70) begin
            c.cmd = CMD_WRITE;
            if ($urandom_range(0, 9) != 0) begin
                c.index = IDX_BITS'($urandom_range(0, n - 1));
            end
            if ($urandom_range(0, 7) == 0) begin
                c.coeff = ($urandom_range(0, 1) == 1) ? 20'sh7FFFF : 20'sh80000;
            end
        end else if (pick < 95) begin
            c.cmd = CMD_READ;
            if ($urandom_range(0, 4) != 0) begin
                c.index = IDX_BITS'($urandom_range(0, n - 1));
            end
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    task automatic send_command(encoder_cmd_t c);
        int unsigned gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.cmd         = c.cmd;
        in_ch.sample      = c.sample;
        in_ch.coeff_index = c.index;
        in_ch.coeff_value = c.coeff;
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_command(c);
    endtask

    task automatic write_register(logic reg_sel, int unsigned value);
        logic [31:0] data;
        data = value;
        // Upper bits beyond the register width must be dropped.
        if ($urandom_range(0, 1) == 1) begin
            data = data | ($urandom & ((reg_sel == REG_ORDER) ? 32'hFFFF_FFF8 : 32'hFF80_0000));
        end
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_register(reg_sel, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Let every expected result drain, then allow for a swap still running.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                out_ch.ready    = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (traffic_steady || $urandom_range(0, 2) != 0) begin
                out_ch.ready = 1'b1;
            end else begin
                out_ch.ready = 1'b0;
                repeat (pick_gap() - 1) @(negedge i_clk);
            end
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            sb.check_result('{out_ch.channel, out_ch.result_value, out_ch.last});
        end
    end

    // Ends a run in which nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL ambisonic_gain_encoder_zc_swap");
                $finish;
            end
        end
    end

    initial begin
        int unsigned  phase_order [PHASES];
        int unsigned  phase_thresh [PHASES];
        int unsigned  counted;
        encoder_cmd_t c;

        phase_order  = '{0, 7, 5, 3, 2, 6, 4};
        phase_thresh = '{0, 8388607, 100000, 8389, 4096, 1048576, 8388606};
        sb = new();

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_ENCODE;
        in_ch.sample      = '0;
        in_ch.coeff_index = '0;
        in_ch.coeff_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset settings: order one (four channels) and
        // the default threshold.
        send_command(make_command(CMD_READ, 0, 0, 0));
        send_command(make_command(CMD_ENCODE, 8388607, 0, 0));
        send_command(make_command(CMD_WRITE, 0, 0, 524287));
        send_command(make_command(CMD_WRITE, 0, 1, -524288));
        send_command(make_command(CMD_WRITE, 0, 2, 1));
        send_command(make_command(CMD_WRITE, 0, 3, -1));
        // Writes past the channel count are dropped.
        send_command(make_command(CMD_WRITE, 0, 4, 777));
        send_command(make_command(CMD_WRITE, 0, 63, -777));
        // The new values stay in the shadow bank until a quiet sample.
        send_command(make_command(CMD_READ, 0, 0, 0));
        send_command(make_command(CMD_ENCODE, 8388607, 0, 0));
        send_command(make_command(CMD_ENCODE, -8388608, 0, 0));
        send_command(make_command(CMD_ENCODE, 8389, 0, 0));
        send_command(make_command(CMD_ENCODE, 8388, 0, 0));
        send_command(make_command(CMD_READ, 0, 1, 0));
        send_command(make_command(CMD_READ, 0, 4, 0));
        send_command(make_command(CMD_READ, 0, 63, 0));
        // Saturation in both directions and rounding of tiny products.
        send_command(make_command(CMD_ENCODE, 8388607, 0, 0));
        send_command(make_command(CMD_ENCODE, -8388608, 0, 0));
        send_command(make_command(CMD_ENCODE, 1, 0, 0));
        send_command(make_command(CMD_ENCODE, -1, 0, 0));
        send_command(make_command(CMD_UNUSED, -1, 63, -1));
        // Exactly at the threshold no swap happens; just below it does.
        send_command(make_command(CMD_WRITE, 0, 2, 12345));
        send_command(make_command(CMD_ENCODE, -8389, 0, 0));
        send_command(make_command(CMD_ENCODE, -8388, 0, 0));
        send_command(make_command(CMD_READ, 0, 2, 0));
        settle();

        // Random phases, each at its own order and threshold.
        for (int p = 0; p < PHASES; p++) begin
            write_register(REG_ORDER, phase_order[p]);
            write_register(REG_THRESH, phase_thresh[p]);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 49) == 0) begin
                    traffic_steady = !traffic_steady;
                end
                // Stall the receiver while commands keep coming.
                if (p == 2 && counted == 10) begin
                    rx_hold_request = 1'b1;
                end
                c = random_command();
                if (!(c.cmd == CMD_UNUSED ||
                      (c.cmd == CMD_WRITE && c.index >= sb.num_channels()))) begin
                    counted++;
                end
                send_command(c);
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("PASS ambisonic_gain_encoder_zc_swap");
        end else begin
            $display("FAIL ambisonic_gain_encoder_zc_swap");
        end
        $finish;
    end

endmodule
